>>> rtl/surdmx_pkg.sv
// Package for the stereo downmix: payload and config types, constants, coefficient builder.
package surdmx_pkg;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 14;
    localparam int GAIN_W         = 15;
    localparam int COEF_W         = 16;
    localparam int LOGICAL        = 8;
    localparam int MAP_W          = 4;
    localparam int LAYOUT_W       = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int SPLIT_FRAC     = 15;
    localparam int SPLIT_PROD_W   = GAIN_W + SPLIT_FRAC;

    localparam logic [SPLIT_FRAC-1:0] SPLIT_Q15 = 15'd23170;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT      = 3'd0,
        REG_POS_MAP     = 3'd1,
        REG_GAIN_LEFT   = 3'd2,
        REG_GAIN_RIGHT  = 3'd3,
        REG_GAIN_CENTER = 3'd4,
        REG_GAIN_SIDE   = 3'd5,
        REG_GAIN_REAR   = 3'd6,
        REG_GAIN_LFE    = 3'd7
    } reg_idx_t;

    localparam logic [LAYOUT_W-1:0] LAYOUT_STEREO    = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_FIVE_ONE  = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SEVEN_ONE = 2'd2;

    // logical channels
    localparam int CH_FL  = 0;
    localparam int CH_FR  = 1;
    localparam int CH_C   = 2;
    localparam int CH_LFE = 3;
    localparam int CH_SL  = 4;
    localparam int CH_SR  = 5;
    localparam int CH_BL  = 6;
    localparam int CH_BR  = 7;

    localparam int SIDE_L = 0;
    localparam int SIDE_R = 1;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic signed [SAMPLE_BITS-1:0] sample_4;
        logic signed [SAMPLE_BITS-1:0] sample_5;
        logic signed [SAMPLE_BITS-1:0] sample_6;
        logic signed [SAMPLE_BITS-1:0] sample_7;
        logic                          frame_last;
    } src_frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          clipped;
        logic                          block_end;
    } mix_result_t;

    typedef struct packed {
        logic [LAYOUT_W-1:0]       layout;
        logic [CHANNELS*MAP_W-1:0] pos_map;
        logic [GAIN_W-1:0]         gain_left;
        logic [GAIN_W-1:0]         gain_right;
        logic [GAIN_W-1:0]         gain_center;
        logic [GAIN_W-1:0]         gain_side;
        logic [GAIN_W-1:0]         gain_rear;
        logic [GAIN_W-1:0]         gain_lfe;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        layout:      2'd1,
        pos_map:     32'hFF54_3210,
        gain_left:   15'd16384,
        gain_right:  15'd16384,
        gain_center: 15'd14746,
        gain_side:   15'd9011,
        gain_rear:   15'd10158,
        gain_lfe:    15'd4096
    };

    // per input position, left then right coefficient
    typedef logic [CHANNELS-1:0][1:0][COEF_W-1:0] pos_coef_t;
    typedef logic [LOGICAL-1:0][1:0][COEF_W-1:0]  log_coef_t;

    // gain * 0.7071 in Q0.15, rounded half up back to the gain format
    function automatic logic [COEF_W-1:0] split_gain(input logic [GAIN_W-1:0] g);
        logic [SPLIT_PROD_W-1:0] t;
        t = SPLIT_PROD_W'(g) * SPLIT_PROD_W'(SPLIT_Q15)
            + (SPLIT_PROD_W'(1) << (SPLIT_FRAC - 1));
        return COEF_W'(t >> SPLIT_FRAC);
    endfunction

    function automatic pos_coef_t build_coefs(input cfg_t c);
        log_coef_t         lc;
        pos_coef_t         pc;
        logic [MAP_W-1:0]  entry;
        logic [COEF_W-1:0] c_split;
        logic [COEF_W-1:0] s_split;
        logic [COEF_W-1:0] r_split;
        lc      = '0;
        c_split = split_gain(c.gain_center);
        s_split = split_gain(c.gain_side);
        r_split = split_gain(c.gain_rear);
        unique case (c.layout) inside
            LAYOUT_FIVE_ONE, LAYOUT_SEVEN_ONE:
            begin
                lc[CH_FL][SIDE_L]  = COEF_W'(c.gain_left);
                lc[CH_FR][SIDE_R]  = COEF_W'(c.gain_right);
                lc[CH_C]           = {c_split, c_split};
                lc[CH_LFE]         = {COEF_W'(c.gain_lfe), COEF_W'(c.gain_lfe)};
                lc[CH_SL]          = {s_split, s_split};
                lc[CH_SR]          = {s_split, s_split};
                if (c.layout == LAYOUT_SEVEN_ONE)
                begin
                    lc[CH_BL] = {r_split, r_split};
                    lc[CH_BR] = {r_split, r_split};
                end
            end
            default:
            begin
                lc[CH_FL][SIDE_L] = COEF_W'(1) << GAIN_FRAC_BITS;
                lc[CH_FR][SIDE_R] = COEF_W'(1) << GAIN_FRAC_BITS;
            end
        endcase
        for (int p = 0; p < CHANNELS; p++)
        begin
            entry = c.pos_map[p*MAP_W +: MAP_W];
            if (entry[MAP_W-1])
                pc[p] = '0;
            else
                pc[p] = lc[entry[MAP_W-2:0]];
        end
        return pc;
    endfunction

endpackage

>>> rtl/surround_stereo_downmix.sv
// Top level of the surround to stereo downmix: config registers, coefficients, mix pipeline.
//
// Usage:
//   src channel: src_valid / src_stall / src_frame carry one interleaved frame of eight
//   signed samples plus frame_last. mix channel: mix_valid / mix_stall / mix_result give
//   the stereo pair, the clip flag and block_end. A request moves when valid is high and
//   stall is low.
//   Config port: cfg_we writes cfg_data into register cfg_index. The coefficient set is
//   rebuilt at the same edge, so a frame taken in the next cycle already uses it.
//   Write only while the pipeline is empty.
// Path: a taken frame passes each stage register below in order before it shows on the mix channel.
// Throughput: one frame per cycle while mix_stall is low; each pipeline stage holds one frame
//   (products, group sums, rounded sum, saturated output register).
// Stall: a stalled output holds; bubbles in the earlier stages still fill, then src_stall
//   rises. Nothing is lost or repeated.
// Reset: pipeline empty; registers take the five point one defaults (map FL FR C LFE SL SR,
//   positions 6 and 7 unused) with matching coefficients.
module surround_stereo_downmix
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [surdmx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [surdmx_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 src_valid,
    output logic                                 src_stall,
    input  surdmx_pkg::src_frame_t               src_frame,
    output logic                                 mix_valid,
    input  logic                                 mix_stall,
    output surdmx_pkg::mix_result_t              mix_result
);

    localparam int SB        = surdmx_pkg::SAMPLE_BITS;
    localparam int CH        = surdmx_pkg::CHANNELS;
    localparam int GFB       = surdmx_pkg::GAIN_FRAC_BITS;
    localparam int PROD_W    = SB + surdmx_pkg::COEF_W + 1;
    localparam int ACC_W     = PROD_W + 3;
    localparam int GROUPS    = 2;
    localparam int PER_GROUP = CH / GROUPS;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (GFB - 1));

    // configuration and coefficients
    surdmx_pkg::cfg_t      cfg_reg;
    surdmx_pkg::cfg_t      cfg_next;
    surdmx_pkg::pos_coef_t coef_reg;
    surdmx_pkg::pos_coef_t coef_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                surdmx_pkg::REG_LAYOUT:
                    cfg_next.layout = cfg_data[surdmx_pkg::LAYOUT_W-1:0];
                surdmx_pkg::REG_POS_MAP:
                    cfg_next.pos_map = cfg_data[CH*surdmx_pkg::MAP_W-1:0];
                surdmx_pkg::REG_GAIN_LEFT:
                    cfg_next.gain_left = cfg_data[surdmx_pkg::GAIN_W-1:0];
                surdmx_pkg::REG_GAIN_RIGHT:
                    cfg_next.gain_right = cfg_data[surdmx_pkg::GAIN_W-1:0];
                surdmx_pkg::REG_GAIN_CENTER:
                    cfg_next.gain_center = cfg_data[surdmx_pkg::GAIN_W-1:0];
                surdmx_pkg::REG_GAIN_SIDE:
                    cfg_next.gain_side = cfg_data[surdmx_pkg::GAIN_W-1:0];
                surdmx_pkg::REG_GAIN_REAR:
                    cfg_next.gain_rear = cfg_data[surdmx_pkg::GAIN_W-1:0];
                surdmx_pkg::REG_GAIN_LFE:
                    cfg_next.gain_lfe = cfg_data[surdmx_pkg::GAIN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
        coef_next = surdmx_pkg::build_coefs(cfg_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= surdmx_pkg::CFG_RESET;
            coef_reg <= surdmx_pkg::build_coefs(surdmx_pkg::CFG_RESET);
        end
        else
        begin
            cfg_reg  <= cfg_next;
            coef_reg <= coef_next;
        end
    end

    // stage enables: a stage loads when it is empty or its successor moves
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic out_vld_reg;
    logic en_out;
    logic en3;
    logic en2;
    logic en1;

    assign en_out    = !out_vld_reg || !mix_stall;
    assign en3       = !s3_vld_reg || en_out;
    assign en2       = !s2_vld_reg || en3;
    assign en1       = !s1_vld_reg || en2;
    assign src_stall = !en1;
    assign mix_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_vld_reg <= src_valid;
            if (en2)
                s2_vld_reg <= s1_vld_reg;
            if (en3)
                s3_vld_reg <= s2_vld_reg;
            if (en_out)
                out_vld_reg <= s3_vld_reg;
        end
    end

    // stage 1: products
    logic signed [SB-1:0]     smp [CH];
    logic signed [PROD_W-1:0] prod_next [CH][2];
    logic signed [PROD_W-1:0] prod_reg  [CH][2];
    logic                     s1_last_reg;

    assign smp[0] = src_frame.sample_0;
    assign smp[1] = src_frame.sample_1;
    assign smp[2] = src_frame.sample_2;
    assign smp[3] = src_frame.sample_3;
    assign smp[4] = src_frame.sample_4;
    assign smp[5] = src_frame.sample_5;
    assign smp[6] = src_frame.sample_6;
    assign smp[7] = src_frame.sample_7;

    always_comb
    begin
        for (int p = 0; p < CH; p++)
        begin
            for (int s = 0; s < 2; s++)
                prod_next[p][s] = smp[p] * $signed({1'b0, coef_reg[p][s]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && src_valid)
        begin
            prod_reg    <= prod_next;
            s1_last_reg <= src_frame.frame_last;
        end
    end

    // stage 2: group sums
    logic signed [ACC_W-1:0] grp_next [2][GROUPS];
    logic signed [ACC_W-1:0] grp_reg  [2][GROUPS];
    logic                    s2_last_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_next[s][g] = '0;
                for (int k = 0; k < PER_GROUP; k++)
                    grp_next[s][g] = grp_next[s][g] + ACC_W'(prod_reg[g*PER_GROUP+k][s]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_vld_reg)
        begin
            grp_reg     <= grp_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: total plus rounding bias
    logic signed [ACC_W-1:0] sum_next [2];
    logic signed [ACC_W-1:0] sum_reg  [2];
    logic                    s3_last_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
            sum_next[s] = grp_reg[s][0] + grp_reg[s][1] + ROUND_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_vld_reg)
        begin
            sum_reg     <= sum_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    // stage 4: scale down, saturate, output register
    logic signed [ACC_W-1:0] shifted [2];
    logic signed [SB-1:0]    sat     [2];
    logic [1:0]              clip;
    surdmx_pkg::mix_result_t mix_result_next;
    surdmx_pkg::mix_result_t mix_result_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            shifted[s] = sum_reg[s] >>> GFB;
            if (shifted[s] > surdmx_pkg::SAT_HI)
            begin
                sat[s]  = surdmx_pkg::SAT_HI;
                clip[s] = 1'b1;
            end
            else if (shifted[s] < surdmx_pkg::SAT_LO)
            begin
                sat[s]  = surdmx_pkg::SAT_LO;
                clip[s] = 1'b1;
            end
            else
            begin
                sat[s]  = shifted[s][SB-1:0];
                clip[s] = 1'b0;
            end
        end
        mix_result_next.left_out  = sat[surdmx_pkg::SIDE_L];
        mix_result_next.right_out = sat[surdmx_pkg::SIDE_R];
        mix_result_next.clipped   = |clip;
        mix_result_next.block_end = s3_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s3_vld_reg)
            mix_result_reg <= mix_result_next;
    end

    assign mix_result = mix_result_reg;

    // checks
    a_coef_tracks_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        coef_reg == surdmx_pkg::build_coefs(cfg_reg))
        else $error("coefficients out of step with registers");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> s1_vld_reg)
        else $error("taken frame did not enter stage 1");

    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg && !en_out |=> s3_vld_reg && $stable(s3_last_reg))
        else $error("stage 3 lost a frame under stall");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && mix_result_reg.clipped |->
            (mix_result_reg.left_out == surdmx_pkg::SAT_HI) ||
            (mix_result_reg.left_out == surdmx_pkg::SAT_LO) ||
            (mix_result_reg.right_out == surdmx_pkg::SAT_HI) ||
            (mix_result_reg.right_out == surdmx_pkg::SAT_LO))
        else $error("clip flag without a saturated side");

endmodule
